### rtl/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

  // UTF-16 constants
  localparam logic [15:0] REPL_CHAR     = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] SURR_FIRST    = 21'h00D800;
  localparam logic [20:0] SURR_LAST     = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [20:0] CODE_LIMIT    = 21'h110000;

  // UTF-8 lead byte boundaries
  localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
  localparam logic [7:0]  LEAD2_FIRST   = 8'hC0;
  localparam logic [7:0]  LEAD3_FIRST   = 8'hE0;
  localparam logic [7:0]  LEAD4_FIRST   = 8'hF0;
  localparam logic [7:0]  LEAD_LIMIT    = 8'hF5;
  localparam logic [1:0]  CONT_TAG      = 2'b10;

  // default depth of the decoupling queue
  localparam int          QUEUE_DEPTH_DEF = 4;

  // one queue entry: one or two code units caused by a single byte
  typedef struct packed {
    logic        two;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } u8u16_entry_t;

endpackage

### rtl/u8u16_front.sv
`timescale 1ns / 1ps

module u8u16_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  output logic                  push,
  output u8u16_pkg::u8u16_entry_t push_entry
);
  import u8u16_pkg::*;

  logic [1:0]  need_r, need_nxt;
  logic [20:0] acc_r, acc_nxt;

  logic        is_cont;
  logic [20:0] acc_cont;
  logic [19:0] supp_off;
  logic        f_valid;
  logic [15:0] f_unit;
  logic [1:0]  f_need;
  logic [20:0] f_acc;
  logic [1:0]  n_units;
  logic [15:0] u0, u1;

  assign is_cont  = (in_byte[7:6] == CONT_TAG);
  assign acc_cont = {acc_r[14:0], in_byte[5:0]};
  assign supp_off = 20'(acc_cont - SUPP_BASE);

  // decode of the byte as if no sequence were pending
  always_comb begin
    f_valid = 1'b0;
    f_unit  = REPL_CHAR;
    f_need  = 2'd0;
    f_acc   = '0;
    priority if (in_byte == 8'h00) begin
      f_valid = 1'b0;
    end else if (in_byte < ASCII_LIMIT) begin
      f_valid = 1'b1;
      f_unit  = {8'h00, in_byte};
    end else if (in_byte < LEAD2_FIRST) begin
      f_valid = 1'b1;
    end else if (in_byte < LEAD3_FIRST) begin
      f_need  = 2'd1;
      f_acc   = {16'h0000, in_byte[4:0]};
    end else if (in_byte < LEAD4_FIRST) begin
      f_need  = 2'd2;
      f_acc   = {17'h00000, in_byte[3:0]};
    end else if (in_byte < LEAD_LIMIT) begin
      f_need  = 2'd3;
      f_acc   = {18'h00000, in_byte[2:0]};
    end else begin
      f_valid = 1'b1;
    end
  end

  // classify against the pending sequence
  always_comb begin
    n_units  = 2'd0;
    u0       = REPL_CHAR;
    u1       = REPL_CHAR;
    need_nxt = need_r;
    acc_nxt  = acc_r;
    if (need_r != 2'd0 && is_cont) begin
      acc_nxt  = acc_cont;
      need_nxt = need_r - 2'd1;
      if (need_r == 2'd1) begin
        // sequence complete
        need_nxt = 2'd0;
        acc_nxt  = '0;
        priority if ((acc_cont >= SURR_FIRST && acc_cont <= SURR_LAST) ||
                     acc_cont >= CODE_LIMIT) begin
          n_units = 2'd1;
        end else if (acc_cont >= SUPP_BASE) begin
          n_units = 2'd2;
          u0      = HI_SURR_BASE | {6'h00, supp_off[19:10]};
          u1      = LO_SURR_BASE | {6'h00, supp_off[9:0]};
        end else begin
          n_units = 2'd1;
          u0      = acc_cont[15:0];
        end
      end
    end else if (need_r != 2'd0) begin
      // interrupted sequence: one replacement, then the byte afresh
      u0       = REPL_CHAR;
      u1       = f_unit;
      n_units  = f_valid ? 2'd2 : 2'd1;
      need_nxt = f_need;
      acc_nxt  = f_acc;
    end else begin
      u0       = f_unit;
      n_units  = {1'b0, f_valid};
      need_nxt = f_need;
      acc_nxt  = f_acc;
    end
  end

  assign push             = accept && (n_units != 2'd0);
  assign push_entry.two   = n_units[1];
  assign push_entry.unit0 = u0;
  assign push_entry.unit1 = u1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 2'd0;
      acc_r  <= '0;
    end else if (accept) begin
      need_r <= need_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

### rtl/u8u16_queue.sv
`timescale 1ns / 1ps

module u8u16_queue #(
  parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  u8u16_pkg::u8u16_entry_t push_entry,
  input  logic                    pop,
  output u8u16_pkg::u8u16_entry_t pop_entry,
  output logic                    full,
  output logic                    empty
);
  import u8u16_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  u8u16_entry_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue read while empty");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy did not follow a write");

endmodule

### rtl/u8u16_back.sv
`timescale 1ns / 1ps

module u8u16_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  u8u16_pkg::u8u16_entry_t q_entry,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_code_unit,
  output logic                    out_run_last
);
  import u8u16_pkg::*;

  u8u16_entry_t ent_r, ent_nxt;
  logic         valid_r, valid_nxt;
  logic         phase_r, phase_nxt;
  logic         take;

  // ready for a new entry when empty or when the final unit leaves
  assign take  = !valid_r || (out_ready && (phase_r || !ent_r.two));
  assign q_pop = take && !q_empty;

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (take) begin
      ent_nxt   = q_entry;
      valid_nxt = !q_empty;
      phase_nxt = 1'b0;
    end else if (out_ready) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign out_valid     = valid_r;
  assign out_code_unit = phase_r ? ent_r.unit1 : ent_r.unit0;
  assign out_run_last  = phase_r || !ent_r.two;

  a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && phase_r) |-> ent_r.two) else $error("second unit of a single entry");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_code_unit)))
    else $error("result changed while stalled");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_run_last) |=> (out_valid && phase_r))
    else $error("low surrogate did not follow");

endmodule

### rtl/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// Channel  Ports                                   Dir  Meaning
// input    in_valid, in_ready, in_byte[7:0]        in   UTF-8 bytes, zero ends a string
// output   out_valid, out_ready,                   out  UTF-16 code units,
//          out_code_unit[15:0], out_run_last            run_last on a byte's final unit
//
// A byte is taken every cycle while the queue has room; its first unit is written to
// the queue, then registered in the output stage once that stage is clear, and offered.
// The output stage sends one code unit a cycle while out_ready is high, so a byte
// that yields a pair occupies it for both units; that stage sets the sustained rate.
// Reset (synchronous, rst_n low) clears the pending sequence, queue and output.
// Output stalls back up through the queue of QUEUE_DEPTH entries to in_ready.

module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_run_last
);
  import u8u16_pkg::*;

  u8u16_entry_t push_entry, pop_entry;
  logic         push, pop, full, empty, accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (full),
    .empty      (empty)
  );

  u8u16_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_entry       (pop_entry),
    .q_empty       (empty),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_unit (out_code_unit),
    .out_run_last  (out_run_last)
  );

endmodule
